// ----- hdl/itl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// itl_pkg
// Types and constants for the impedance torque core: the sample and result
// layouts, the register map and the per-motor position limits.
// ----------------------------------------------------------------------------
package itl_pkg;

  localparam int unsigned MotorCount = 12;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    REG_STIFFNESS = 2'd0,
    REG_DAMPING   = 2'd1,
    REG_TORQUE    = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_e;

  localparam logic [15:0] StiffnessReset = 16'd2560;
  localparam logic [15:0] DampingReset   = 16'd256;
  localparam logic [14:0] TorqueReset    = 15'd2560;

  // Q3.12 limits: 2.8, 1.5, 3.14, 2.1, 3.0, 0.5, repeated for the second arm
  localparam logic [15:0] MotorLimit [16] = '{
    16'd11469, 16'd6144, 16'd12861, 16'd8602, 16'd12288, 16'd2048,
    16'd11469, 16'd6144, 16'd12861, 16'd8602, 16'd12288, 16'd2048,
    16'd11469, 16'd6144, 16'd12861, 16'd8602
  };

  typedef struct packed {
    logic [3:0]         motor_index;
    logic signed [15:0] target_position;
    logic signed [15:0] target_velocity;
    logic signed [15:0] measured_position;
    logic signed [15:0] measured_velocity;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] limited_position;
    logic signed [15:0] command_velocity;
    logic signed [15:0] drive_torque;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/impedance_torque_with_limits_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// impedance_torque_with_limits_core
// PD impedance torque for one motor sample per cycle: per-motor target clamp,
// kp*pos_err + kd*vel_err in fixed point, floor shift to Q7.8, saturation.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  direction  transaction
//  sample    start, busy, cmd_i                       in         start & !busy
//  result    done_o, result_o                         out        done_o, one cycle
//  config    psel, penable, pwrite, paddr, pwdata,    in/out     APB write/read
//            prdata, pready
//
// Five register stages: clamp, errors, products, sum and shift, saturate.
// One sample per cycle sustained.
// busy stays low: the result side cannot stall, so nothing ever holds.
// Reset clears the valid chain and loads the gain and limit defaults.
//
module impedance_torque_with_limits_core
  import itl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire sample_t              cmd_i,
  output logic                      done_o,
  output result_t                   result_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0]      prdata,
  output logic                      pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] kp_q, kd_q;
  logic [14:0] tl_q;
  reg_idx_e    reg_sel;
  logic        wr_en;

  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= StiffnessReset;
      kd_q <= DampingReset;
      tl_q <= TorqueReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_STIFFNESS: kp_q <= pwdata[15:0];
        REG_DAMPING:   kd_q <= pwdata[15:0];
        REG_TORQUE:    tl_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STIFFNESS: prdata = {16'd0, kp_q};
      REG_DAMPING:   prdata = {16'd0, kd_q};
      REG_TORQUE:    prdata = {17'd0, tl_q};
      default:       prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Valid chain
  // --------------------------------------------------------------------------
  logic [4:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start & ~busy};
    end
  end

  assign done_o = vld_q[4];

  // --------------------------------------------------------------------------
  // Stage 1: clamp target position
  // --------------------------------------------------------------------------
  logic signed [15:0] lim_pos, lim_hi, lim_lo;
  logic signed [15:0] s1_pos_q, s1_tvel_q, s1_mpos_q, s1_mvel_q;

  assign lim_hi = $signed(MotorLimit[cmd_i.motor_index]);
  assign lim_lo = -lim_hi;

  always_comb begin
    lim_pos = cmd_i.target_position;
    if ({28'd0, cmd_i.motor_index} < MotorCount) begin
      priority if (cmd_i.target_position > lim_hi) begin
        lim_pos = lim_hi;
      end else if (cmd_i.target_position < lim_lo) begin
        lim_pos = lim_lo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pos_q  <= lim_pos;
    s1_tvel_q <= cmd_i.target_velocity;
    s1_mpos_q <= cmd_i.measured_position;
    s1_mvel_q <= cmd_i.measured_velocity;
  end

  // --------------------------------------------------------------------------
  // Stage 2: errors at 17 bits
  // --------------------------------------------------------------------------
  logic signed [16:0] s2_perr_q, s2_verr_q;
  logic signed [15:0] s2_pos_q, s2_tvel_q;

  always_ff @(posedge clk_i) begin
    s2_perr_q <= 17'(s1_pos_q) - 17'(s1_mpos_q);
    s2_verr_q <= 17'(s1_tvel_q) - 17'(s1_mvel_q);
    s2_pos_q  <= s1_pos_q;
    s2_tvel_q <= s1_tvel_q;
  end

  // --------------------------------------------------------------------------
  // Stage 3: products, kp*pos_err is Q.20, kd*vel_err is Q.16
  // --------------------------------------------------------------------------
  logic signed [33:0] s3_pprod_q, s3_vprod_q;
  logic signed [15:0] s3_pos_q, s3_tvel_q;

  always_ff @(posedge clk_i) begin
    s3_pprod_q <= 34'($signed({1'b0, kp_q}) * s2_perr_q);
    s3_vprod_q <= 34'($signed({1'b0, kd_q}) * s2_verr_q);
    s3_pos_q   <= s2_pos_q;
    s3_tvel_q  <= s2_tvel_q;
  end

  // --------------------------------------------------------------------------
  // Stage 4: align, sum, floor shift to Q7.8
  // --------------------------------------------------------------------------
  logic signed [38:0] acc;
  logic signed [26:0] s4_torque_q;
  logic signed [15:0] s4_pos_q, s4_tvel_q;

  assign acc = 39'(s3_pprod_q) + (39'(s3_vprod_q) <<< 4);

  always_ff @(posedge clk_i) begin
    s4_torque_q <= 27'(acc >>> 12);
    s4_pos_q    <= s3_pos_q;
    s4_tvel_q   <= s3_tvel_q;
  end

  // --------------------------------------------------------------------------
  // Stage 5: saturate to +/- torque_limit
  // --------------------------------------------------------------------------
  logic signed [26:0] tl_pos, tl_neg;
  logic signed [15:0] sat_torque;
  result_t            res_q;

  assign tl_pos = $signed({12'd0, tl_q});
  assign tl_neg = -tl_pos;

  always_comb begin
    priority if (s4_torque_q > tl_pos) begin
      sat_torque = tl_pos[15:0];
    end else if (s4_torque_q < tl_neg) begin
      sat_torque = tl_neg[15:0];
    end else begin
      sat_torque = s4_torque_q[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.limited_position <= s4_pos_q;
    res_q.command_velocity <= s4_tvel_q;
    res_q.drive_torque     <= sat_torque;
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Impedance torque core testbench
// Feeds motor samples through the command port and compares every result
// with a local fixed-point model of the clamp, the PD torque and the
// saturation. Gains are changed over the APB port between phases, with
// read-back, across zero, full-scale, unit and random settings.
// ----------------------------------------------------------------------------
module testbench
  import itl_pkg::*;
;

  // Q3.12 position limits, one entry per joint of an arm
  localparam int POS_LIMIT [6] = '{11469, 6144, 12861, 8602, 12288, 2048};
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 155;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 start   = 1'b0;
  sample_t              cmd     = '0;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [AddrWidth-1:0] paddr   = '0;
  logic [DataWidth-1:0] pwdata  = '0;
  logic                 busy;
  logic                 done_o;
  result_t              result_o;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  impedance_torque_with_limits_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  class torque_checker;
    int      stiffness;
    int      damping;
    int      torque_limit;
    result_t expected_commands [$];
    int      errors;
    int      reported;
    int      samples_noted;
    int      results_checked;

    function new();
      stiffness    = StiffnessReset;
      damping      = DampingReset;
      torque_limit = TorqueReset;
    endfunction

    function void report(string what);
      errors++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("[%0t] mismatch: %s", $realtime, what);
      end
    endfunction

    function void load_reg(reg_idx_e r, logic [31:0] v);
      case (r)
        REG_STIFFNESS: stiffness = v[15:0];
        REG_DAMPING:   damping = v[15:0];
        REG_TORQUE:    torque_limit = v[14:0];
        default: ;
      endcase
    endfunction

    function void check_reg(reg_idx_e r, logic [31:0] got);
      logic [31:0] want;
      case (r)
        REG_STIFFNESS: want = 32'(stiffness);
        REG_DAMPING:   want = 32'(damping);
        default:       want = 32'(torque_limit);
      endcase
      if (got !== want)
        report($sformatf("register %s read %0h, expected %0h", r.name(), got, want));
    endfunction

    // clamp the target, form kp*pos_err + kd*vel_err, floor to Q7.8, saturate
    function result_t compute_command(sample_t s);
      longint  lim_pos;
      longint  pos_err;
      longint  vel_err;
      longint  acc;
      longint  torque;
      longint  lim;
      result_t r;
      lim_pos = longint'($signed(s.target_position));
      if (s.motor_index < MotorCount) begin
        lim = POS_LIMIT[s.motor_index % 6];
        if (lim_pos > lim) lim_pos = lim;
        if (lim_pos < -lim) lim_pos = -lim;
      end
      pos_err = lim_pos - longint'($signed(s.measured_position));
      vel_err = longint'($signed(s.target_velocity)) - longint'($signed(s.measured_velocity));
      acc = longint'(stiffness) * pos_err + longint'(damping) * vel_err * 16;
      torque = acc >>> 12;
      if (torque > longint'(torque_limit)) torque = torque_limit;
      if (torque < -longint'(torque_limit)) torque = -longint'(torque_limit);
      r.limited_position = 16'(lim_pos);
      r.command_velocity = s.target_velocity;
      r.drive_torque     = 16'(torque);
      return r;
    endfunction

    function void note_sample(sample_t s);
      samples_noted++;
      expected_commands.push_back(compute_command(s));
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_checked++;
      if (expected_commands.size() == 0) begin
        report($sformatf("result with nothing pending: pos %0d vel %0d torque %0d",
                         got.limited_position, got.command_velocity, got.drive_torque));
        return;
      end
      want = expected_commands.pop_front();
      if (got !== want)
        report($sformatf("pos %0d/%0d vel %0d/%0d torque %0d/%0d (got/expected)",
                         got.limited_position, want.limited_position,
                         got.command_velocity, want.command_velocity,
                         got.drive_torque, want.drive_torque));
    endfunction

    function void close_out();
      if (expected_commands.size() != 0)
        report($sformatf("%0d results never arrived", expected_commands.size()));
    endfunction
  endclass

  torque_checker chk;
  int            settings_used;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // values seen here are the ones before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) chk.note_sample(cmd);
      if (done_o) chk.check_result(result_o);
    end
  end

  task automatic drive_sample(input sample_t s, input int idle_pct);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd   <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drive_fields(input int idx, input int tp, input int tv,
                              input int mp, input int mv);
    sample_t s;
    s.motor_index       = 4'(idx);
    s.target_position   = 16'(tp);
    s.target_velocity   = 16'(tv);
    s.measured_position = 16'(mp);
    s.measured_velocity = 16'(mv);
    drive_sample(s, 30);
  endtask

  task automatic apb_transfer(input logic wr, input reg_idx_e r, input logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrWidth'({r, 2'b00});
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (wr) chk.load_reg(r, v);
    else chk.check_reg(r, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_back_all();
    apb_transfer(1'b0, REG_STIFFNESS, '0);
    apb_transfer(1'b0, REG_DAMPING, '0);
    apb_transfer(1'b0, REG_TORQUE, '0);
  endtask

  task automatic set_gains(input int kp, input int kd, input int tl);
    apb_transfer(1'b1, REG_STIFFNESS, 32'(kp));
    apb_transfer(1'b1, REG_DAMPING, 32'(kd));
    apb_transfer(1'b1, REG_TORQUE, 32'(tl));
    read_back_all();
    settings_used++;
  endtask

  // drop start and hold until every pending transaction has returned
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (chk.expected_commands.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      lim;
    int      tp;
    s.motor_index = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                                : 4'($urandom_range(0, 11));
    lim = POS_LIMIT[s.motor_index % 6];
    case ($urandom_range(0, 3))
      0: begin
        s.target_position   = 16'($urandom);
        s.target_velocity   = 16'($urandom);
        s.measured_position = 16'($urandom);
        s.measured_velocity = 16'($urandom);
      end
      1: begin
        // straddle the clamp boundary on either side
        tp = lim + $urandom_range(0, 8) - 4;
        if ($urandom_range(0, 1)) tp = -tp;
        s.target_position   = 16'(tp);
        s.measured_position = 16'(tp + $urandom_range(0, 1024) - 512);
        s.target_velocity   = 16'(int'($urandom_range(0, 1023)) - 512);
        s.measured_velocity = 16'(int'($urandom_range(0, 1023)) - 512);
      end
      2: begin
        s.target_position   = 16'(int'($urandom_range(0, 4095)) - 2048);
        s.target_velocity   = 16'(int'($urandom_range(0, 4095)) - 2048);
        s.measured_position = 16'(int'($urandom_range(0, 4095)) - 2048);
        s.measured_velocity = 16'(int'($urandom_range(0, 4095)) - 2048);
      end
      default: begin
        s.target_position   = 16'(pick_extreme());
        s.target_velocity   = 16'(pick_extreme());
        s.measured_position = 16'(pick_extreme());
        s.measured_velocity = 16'(pick_extreme());
      end
    endcase
    return s;
  endfunction

  initial begin
    int idle_pct;
    chk = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    read_back_all();

    // clamp every motor on one side, alternating high and low, then the indexes past the motor count
    for (int i = 0; i < 12; i++) drive_fields(i, (i % 2) ? -32768 : 32767, 256, 0, 0);
    for (int i = 12; i < 16; i++) drive_fields(i, (i % 2) ? -32768 : 32767, -256, 4096, 0);
    drive_fields(0, 11469, 0, 11469, 0);
    drive_fields(5, -2048, 32767, 32767, -32768);
    drive_fields(2, 100, -32768, -32768, 32767);
    drive_fields(3, 0, 0, 0, 0);
    drive_fields(4, 12289, -1, -12288, 1);
    drive_fields(1, -6145, 1, 6144, -1);
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_gains(65535, 65535, 32767);
        1: set_gains(0, 0, 0);
        2: begin
          apb_transfer(1'b1, REG_NONE, $urandom);
          set_gains($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 32767));
        end
        3: set_gains(256, 0, 32767);
        4: set_gains(0, 65535, 1);
        default: set_gains($urandom_range(0, 4095), $urandom_range(0, 1023),
                           $urandom_range(0, 32767));
      endcase
      idle_pct = (ph < 2) ? 30 : (ph < 4) ? 85 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) drive_sample(random_sample(), idle_pct);
      drain_results();
    end

    repeat (10) @(posedge clk_i);
    chk.close_out();
    $display("summary: %0d samples, %0d results checked, %0d gain settings",
             chk.samples_noted, chk.results_checked, settings_used);
    $display("summary: covered clamps on all motors, unclamped indexes, zero and full gains");
    if (chk.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches in total", chk.errors);
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting on the core");
    $display("testbench: errors");
    $finish;
  end

endmodule
